>>> hw/rtl/rkp_pkg.sv
// Package for the radix key packer: base and length constants, digit code
// tables, status and kind codes and the sequencer state type.
// No dependencies; used by every module of the block.
package rkp_pkg;

  localparam int unsigned BASE      = 40;
  localparam int unsigned MAX_CHARS = 6;

  // Width of one base digit, and the reciprocal used to divide by BASE.
  localparam int unsigned DIG_W   = $clog2(BASE);
  localparam int unsigned SHIFT   = 32 + DIG_W;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam logic [MUL_A_W-1:0] RECIP =
    MUL_A_W'(((64'd1 << SHIFT) + 64'(BASE) - 64'd1) / 64'(BASE));

  localparam int unsigned CNT_W = 3;
  localparam int unsigned IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Symbol bytes and digit codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  localparam logic [DIG_W-1:0] CODE_NONE     = DIG_W'(0);
  localparam logic [DIG_W-1:0] CODE_NINE     = DIG_W'(10);
  localparam logic [DIG_W-1:0] CODE_LETTER_A = DIG_W'(11);
  localparam logic [DIG_W-1:0] CODE_LETTER_Z = DIG_W'(36);
  localparam logic [DIG_W-1:0] CODE_DASH     = DIG_W'(37);
  localparam logic [DIG_W-1:0] CODE_UNDER    = DIG_W'(38);

  typedef enum logic {
    ACT_PACK   = 1'b0,
    ACT_UNPACK = 1'b1
  } action_t;

  typedef enum logic {
    KIND_PACK = 1'b0,
    KIND_CHAR = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BADSYM  = 2'd1,
    STAT_BADHASH = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_UMUL,
    S_UDIG,
    S_OUT
  } state_t;

  // Digit code of a key byte; zero for anything that is not a symbol.
  function automatic logic [DIG_W-1:0] sym_code(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO + 8'd1;
    end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      t = c - CH_LOW_A + 8'(CODE_LETTER_A);
    end else if (c == CH_DASH) begin
      t = 8'(CODE_DASH);
    end else if (c == CH_UNDER) begin
      t = 8'(CODE_UNDER);
    end
    return DIG_W'(t);
  endfunction

  // Character of a digit code from one to the underscore code.
  function automatic logic [7:0] code_char(input logic [DIG_W-1:0] d);
    logic [7:0] t;
    if (d <= CODE_NINE) begin
      t = CH_ZERO + 8'(d) - 8'd1;
    end else if (d <= CODE_LETTER_Z) begin
      t = CH_LOW_A + 8'(d) - 8'(CODE_LETTER_A);
    end else if (d == CODE_DASH) begin
      t = CH_DASH;
    end else begin
      t = CH_UNDER;
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/radix_key_pack_unpack.sv
// Packing: per character a product in the shared multiplier, then the add;
// the result of a finished key is offered in the state after the add.
// Unpacking: per base digit a reciprocal product, then the remainder, for at
// most MAX_CHARS digits; then one transfer per character or one bad-hash result.
// in_tready is high only while idle and no result is waiting.
// rst_n is synchronous; it clears the packing state and the sequencer.
module radix_key_pack_unpack (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] char_in, [39:8] hash_in
  input  logic [rkp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] action
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [1:0] status, [33:2] hash_value, [41:34] char_out, [47:42] zero
  output logic [rkp_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] kind
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import rkp_pkg::*;

  state_t            state_r, state_nxt;
  logic [31:0]       sum_r, sum_nxt;
  logic [31:0]       weight_r, weight_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic              failed_r, failed_nxt;
  logic              eok_r, eok_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  kind_t             kind_r, kind_nxt;
  status_t           status_r, status_nxt;
  logic [31:0]       hash_r, hash_nxt;
  logic [DIG_W-1:0]  dig_r [MAX_CHARS];
  logic              dig_we;

  logic                  mul_en;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod_r;

  logic [7:0]        in_char;
  logic [31:0]       in_hash;
  logic              in_xfer;
  logic              out_xfer;
  logic [DIG_W-1:0]  in_code;
  logic [31:0]       quot;
  logic [31:0]       rem_full;
  logic [DIG_W-1:0]  digit;
  logic              digit_bad;
  logic [7:0]        out_char;
  logic              out_last;
  logic [31:0]       out_hash;

  rkp_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign in_char  = in_tdata[7:0];
  assign in_hash  = in_tdata[39:8];
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign in_code  = sym_code(in_char);

  // Quotient by the reciprocal product, remainder by a constant multiply.
  assign quot      = 32'(prod_r >> SHIFT);
  assign rem_full  = val_r - 32'(quot * 32'(BASE));
  assign digit     = rem_full[DIG_W-1:0];
  assign digit_bad = (digit == CODE_NONE) || (digit > CODE_UNDER);

  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    weight_nxt = weight_r;
    taken_nxt  = taken_r;
    failed_nxt = failed_r;
    eok_nxt    = eok_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    hash_nxt   = hash_r;
    dig_we     = 1'b0;
    mul_en     = 1'b0;
    mul_a      = RECIP;
    mul_b      = val_r;
    in_tready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          if (in_tuser == ACT_PACK) begin
            eok_nxt = in_tlast;
            mul_en  = 1'b1;
            mul_b   = weight_r;
            // Characters beyond the key limit add nothing and fail nothing.
            if (taken_r < CNT_W'(MAX_CHARS)) begin
              mul_a      = MUL_A_W'(in_code);
              failed_nxt = failed_r || (in_code == CODE_NONE);
              weight_nxt = 32'(weight_r * 32'(BASE));
              taken_nxt  = taken_r + CNT_W'(1);
            end else begin
              mul_a = '0;
            end
            state_nxt = S_ACC;
          end else if (in_hash == 32'd0) begin
            kind_nxt   = KIND_CHAR;
            status_nxt = STAT_BADHASH;
            idx_nxt    = '0;
            state_nxt  = S_OUT;
          end else begin
            val_nxt   = in_hash;
            cnt_nxt   = '0;
            mul_en    = 1'b1;
            mul_b     = in_hash;
            state_nxt = S_UDIG;
          end
        end
      end

      S_ACC: begin
        sum_nxt = sum_r + prod_r[31:0];
        if (eok_r) begin
          kind_nxt   = KIND_PACK;
          status_nxt = failed_r ? STAT_BADSYM : STAT_OK;
          hash_nxt   = failed_r ? 32'd0 : sum_r + prod_r[31:0];
          idx_nxt    = '0;
          sum_nxt    = 32'd0;
          weight_nxt = 32'd1;
          taken_nxt  = '0;
          failed_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_UMUL: begin
        mul_en    = 1'b1;
        state_nxt = S_UDIG;
      end

      S_UDIG: begin
        kind_nxt = KIND_CHAR;
        idx_nxt  = '0;
        if (digit_bad) begin
          status_nxt = STAT_BADHASH;
          state_nxt  = S_OUT;
        end else begin
          dig_we  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          val_nxt = quot;
          if (quot == 32'd0) begin
            status_nxt = STAT_OK;
            state_nxt  = S_OUT;
          end else if (cnt_r + CNT_W'(1) == CNT_W'(MAX_CHARS)) begin
            // More digits than a key may hold.
            status_nxt = STAT_BADHASH;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_UMUL;
          end
        end
      end

      S_OUT: begin
        if (out_xfer) begin
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sum_r    <= 32'd0;
      weight_r <= 32'd1;
      taken_r  <= '0;
      failed_r <= 1'b0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      sum_r    <= sum_nxt;
      weight_r <= weight_nxt;
      taken_r  <= taken_nxt;
      failed_r <= failed_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eok_r    <= eok_nxt;
    val_r    <= val_nxt;
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    hash_r   <= hash_nxt;
    if (dig_we) begin
      dig_r[cnt_r[IDX_W-1:0]] <= digit;
    end
  end

  // Result payload: characters are decoded from the stored digits as they go.
  always_comb begin
    out_char = 8'd0;
    out_last = 1'b1;
    out_hash = 32'd0;
    if (kind_r == KIND_CHAR) begin
      if (status_r == STAT_OK) begin
        out_char = code_char(dig_r[idx_r[IDX_W-1:0]]);
        out_last = (idx_r + CNT_W'(1) == cnt_r);
      end
    end else begin
      out_hash = hash_r;
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = kind_r;
  assign out_tlast  = out_last;
  assign out_tdata  = {6'd0, out_char, out_hash, status_r};

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is waiting");

  a_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == ACT_UNPACK && in_hash == 32'd0
    |=> out_tvalid && out_tuser == KIND_CHAR && status_r == STAT_BADHASH && out_tlast)
    else $error("zero packed value did not give a single bad-hash result");

  a_key_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == ACT_PACK && in_tlast
    |-> ##2 out_tvalid && out_tuser == KIND_PACK && out_tlast)
    else $error("finished key gave no packed result");

  a_key_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == ACT_PACK && !in_tlast |-> ##2 in_tready && !out_tvalid)
    else $error("open key character did not return to idle");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && kind_r == KIND_CHAR && status_r == STAT_OK
    |-> idx_r < cnt_r && cnt_r <= CNT_W'(MAX_CHARS))
    else $error("character index beyond the decoded digits");
`endif

endmodule

>>> hw/rtl/rkp_mul.sv
// Shared registered multiplier of the radix key packer.
// Serves both the place-value products and the reciprocal division.
// Depends on rkp_pkg.
module rkp_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rkp_pkg::MUL_A_W-1:0] a,
  input  logic [rkp_pkg::MUL_B_W-1:0] b,
  output logic [rkp_pkg::PROD_W-1:0]  prod_r
);
  import rkp_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule
